/* rtl/ulb_pkg.sv */
// Shared types and constants for the UART command LED blinker.
package ulb_pkg;

    // Default counter width
    localparam int COUNT_BITS_DEF = 16;

    // Configuration register file
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_HALF = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_PER  = 1'd1;
    localparam logic [CFG_W-1:0] STOP_HALF_RESET = 16'd1000;
    localparam logic [CFG_W-1:0] ECHO_PER_RESET  = 16'd1000;

    // Item kinds carried in s_tuser
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Characters of the command language
    localparam logic [7:0] CHR_NUL  = 8'h00;
    localparam logic [7:0] CHR_EQ   = 8'h3D;
    localparam logic [7:0] CHR_ZERO = 8'h30;
    localparam logic [7:0] CHR_NINE = 8'h39;
    localparam logic [7:0] CHR_O_LO = 8'h6F;
    localparam logic [7:0] CHR_O_UP = 8'h4F;
    localparam logic [7:0] CHR_A_LO = 8'h61;
    localparam logic [7:0] CHR_A_UP = 8'h41;
    localparam logic [7:0] CHR_F_LO = 8'h66;
    localparam logic [7:0] CHR_F_UP = 8'h46;
    localparam logic [7:0] CHR_N_LO = 8'h6E;
    localparam logic [7:0] CHR_N_UP = 8'h4E;

    // Command positions: mode and selector are kept, the count stops at POS_SAT
    localparam logic [2:0] POS_MODE = 3'd2;
    localparam logic [2:0] POS_SEL  = 3'd4;
    localparam logic [2:0] POS_SAT  = 3'd5;

    // Mode and echo state set by commands, used by the blinker
    typedef struct packed {
        logic mode_stop;
        logic echo_on;
    } bl_ctrl_t;

endpackage

/* rtl/ulb_cmd_parser.sv */
// Command byte parser: position capture, number accumulation, command decode.
module ulb_cmd_parser
    import ulb_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  logic                  is_tick,
    input  logic [7:0]            rx_byte,
    output bl_ctrl_t              ctrl,
    output bl_ctrl_t              ctrl_next,
    output logic [COUNT_BITS-1:0] on_ticks,
    output logic [COUNT_BITS-1:0] off_ticks
);

    logic [2:0]            char_pos_reg, char_pos_next;
    logic [7:0]            third_reg, third_next;
    logic [7:0]            fifth_reg, fifth_next;
    logic                  equal_reg, equal_next;
    logic                  ended_reg, ended_next;
    logic [COUNT_BITS-1:0] num_reg, num_next;
    logic [COUNT_BITS-1:0] on_reg, on_next;
    logic [COUNT_BITS-1:0] off_reg, off_next;
    bl_ctrl_t              ctrl_reg;
    bl_ctrl_t              ctrl_nx;

    logic                  take;
    logic                  is_digit;
    logic [COUNT_BITS-1:0] num_times10;

    assign take        = fire && (is_tick == OP_BYTE);
    assign is_digit    = (rx_byte >= CHR_ZERO) && (rx_byte <= CHR_NINE);
    // acc * 10 = acc * 8 + acc * 2, wraps at the counter width
    assign num_times10 = (num_reg << 3) + (num_reg << 1);

    // Next state for one byte transaction
    always_comb begin
        char_pos_next = char_pos_reg;
        third_next    = third_reg;
        fifth_next    = fifth_reg;
        equal_next    = equal_reg;
        ended_next    = ended_reg;
        num_next      = num_reg;
        on_next       = on_reg;
        off_next      = off_reg;
        ctrl_nx       = ctrl_reg;
        if (take) begin
            if (rx_byte == CHR_NUL) begin
                // End of command: decode, then clear the command buffer
                if (third_reg == CHR_O_LO || third_reg == CHR_O_UP) begin
                    ctrl_nx.mode_stop = 1'b1;
                    ctrl_nx.echo_on   = 1'b0;
                end else if (third_reg == CHR_A_LO || third_reg == CHR_A_UP) begin
                    ctrl_nx.mode_stop = 1'b0;
                    ctrl_nx.echo_on   = 1'b1;
                end else if (equal_reg) begin
                    if (fifth_reg == CHR_F_LO || fifth_reg == CHR_F_UP) begin
                        off_next = num_reg;
                    end else if (fifth_reg == CHR_N_LO || fifth_reg == CHR_N_UP) begin
                        on_next = num_reg;
                    end
                end
                char_pos_next = '0;
                third_next    = '0;
                fifth_next    = '0;
                equal_next    = 1'b0;
                ended_next    = 1'b0;
                num_next      = '0;
            end else begin
                if (char_pos_reg == POS_MODE) begin
                    third_next = rx_byte;
                end else if (char_pos_reg == POS_SEL) begin
                    fifth_next = rx_byte;
                end
                if (char_pos_reg < POS_SAT) begin
                    char_pos_next = char_pos_reg + 3'd1;
                end
                // Number: digits right after the first '='
                if (!equal_reg) begin
                    if (rx_byte == CHR_EQ) begin
                        equal_next = 1'b1;
                        num_next   = '0;
                    end
                end else if (!ended_reg) begin
                    if (is_digit) begin
                        num_next = num_times10 + COUNT_BITS'(rx_byte[3:0]);
                    end else begin
                        ended_next = 1'b1;
                    end
                end
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_pos_reg <= '0;
            third_reg    <= '0;
            fifth_reg    <= '0;
            equal_reg    <= 1'b0;
            ended_reg    <= 1'b0;
            num_reg      <= '0;
            on_reg       <= '0;
            off_reg      <= '0;
            ctrl_reg     <= '0;
        end else begin
            char_pos_reg <= char_pos_next;
            third_reg    <= third_next;
            fifth_reg    <= fifth_next;
            equal_reg    <= equal_next;
            ended_reg    <= ended_next;
            num_reg      <= num_next;
            on_reg       <= on_next;
            off_reg      <= off_next;
            ctrl_reg     <= ctrl_nx;
        end
    end

    assign ctrl      = ctrl_reg;
    assign ctrl_next = ctrl_nx;
    assign on_ticks  = on_reg;
    assign off_ticks = off_reg;

    // A NUL always restarts the command
    a_nul_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && rx_byte == CHR_NUL) |=> (char_pos_reg == '0 && !equal_reg))
        else $error("command not cleared after NUL");

endmodule

/* rtl/ulb_blinker.sv */
// Tick-driven LED blinker, echo pulse generator and period registers.
module ulb_blinker
    import ulb_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  fire,
    input  logic                  is_tick,
    input  bl_ctrl_t              ctrl,
    input  logic [COUNT_BITS-1:0] on_ticks,
    input  logic [COUNT_BITS-1:0] off_ticks,
    output logic                  lit_next,
    output logic                  pulse
);

    // Compare width covering both counters and 16-bit periods
    localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

    logic [CFG_W-1:0]      stop_half_reg;
    logic [CFG_W-1:0]      echo_per_reg;
    logic [COUNT_BITS-1:0] run_count_reg, run_count_next;
    logic [COUNT_BITS-1:0] stop_count_reg, stop_count_next;
    logic [COUNT_BITS-1:0] echo_count_reg, echo_count_next;
    logic                  lit_reg, lit_nx;
    logic                  pulse_nx;

    logic                  tick;
    logic [COUNT_BITS-1:0] run_inc, stop_inc, echo_inc;

    assign tick     = fire && (is_tick == OP_TICK);
    assign run_inc  = run_count_reg + COUNT_BITS'(1);
    assign stop_inc = stop_count_reg + COUNT_BITS'(1);
    assign echo_inc = echo_count_reg + COUNT_BITS'(1);

    // Period registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_half_reg <= STOP_HALF_RESET;
            echo_per_reg  <= ECHO_PER_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_STOP_HALF: stop_half_reg <= cfg_wdata;
                REG_ECHO_PER:  echo_per_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Next state for one tick transaction
    always_comb begin
        run_count_next  = run_count_reg;
        stop_count_next = stop_count_reg;
        echo_count_next = echo_count_reg;
        lit_nx          = lit_reg;
        pulse_nx        = 1'b0;
        if (tick) begin
            if (ctrl.mode_stop) begin
                stop_count_next = stop_inc;
                if (CMP_W'(stop_inc) == CMP_W'(stop_half_reg)) begin
                    lit_nx          = !lit_reg;
                    stop_count_next = '0;
                end
                run_count_next = '0;
            end else begin
                run_count_next = run_inc;
                if (!lit_reg && run_inc == on_ticks) begin
                    lit_nx         = 1'b1;
                    run_count_next = '0;
                end else if (lit_reg && run_inc == off_ticks) begin
                    lit_nx         = 1'b0;
                    run_count_next = '0;
                end
            end
            // Echo pulse generator
            if (ctrl.echo_on) begin
                echo_count_next = echo_inc;
                if (CMP_W'(echo_inc) == CMP_W'(echo_per_reg)) begin
                    pulse_nx        = 1'b1;
                    echo_count_next = '0;
                end
            end else begin
                echo_count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_count_reg  <= '0;
            stop_count_reg <= '0;
            echo_count_reg <= '0;
            lit_reg        <= 1'b0;
        end else begin
            run_count_reg  <= run_count_next;
            stop_count_reg <= stop_count_next;
            echo_count_reg <= echo_count_next;
            lit_reg        <= lit_nx;
        end
    end

    assign lit_next = lit_nx;
    assign pulse    = pulse_nx;

    // Stop mode parks the run counter
    a_run_parked: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick && ctrl.mode_stop) |=> (run_count_reg == '0))
        else $error("run counter moved in stop mode");

    // A tick with echo off clears the echo counter
    a_echo_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick && !ctrl.echo_on) |=> (echo_count_reg == '0))
        else $error("echo counter moved with echo off");

endmodule

/* rtl/uart_command_led_blinker.sv */
// Top level of the UART command LED blinker: input and result stages.
//
//  Channel  Ports                     Direction  Contents
//  s_       tvalid tready tdata tuser  in         rx_byte, opcode (byte or tick)
//  m_       tvalid tready tdata        out        led_lit, stop_mode, echo_pulse
//  cfg_     we addr wdata              in         stop_half_period, echo_period
//
// One transaction per cycle sustained unless the result stage stalls; each
// input passes the input register, then update and the result register.
// The path between them is one compare per counter or one multiply-by-ten add.
// Synchronous active-low aresetn clears valid and control state; periods go to 1000.
// A stalled result stage holds a full input stage; s_tready then drops.
module uart_command_led_blinker
    import ulb_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    input  logic                 s_tuser,   // [0] opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [0] led_lit, [1] stop_mode, [2] echo_pulse
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic                  in_valid_reg;
    logic                  in_tick_reg;
    logic [7:0]            in_byte_reg;
    logic                  out_valid_reg;
    logic [7:0]            out_data_reg;

    logic                  can_out;
    logic                  fire;
    bl_ctrl_t              ctrl;
    bl_ctrl_t              ctrl_next;
    logic [COUNT_BITS-1:0] on_ticks;
    logic [COUNT_BITS-1:0] off_ticks;
    logic                  lit_next;
    logic                  pulse;

    assign can_out  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && can_out;
    assign s_tready = !in_valid_reg || can_out;

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_tick_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    ulb_cmd_parser #(
        .COUNT_BITS(COUNT_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .is_tick   (in_tick_reg),
        .rx_byte   (in_byte_reg),
        .ctrl      (ctrl),
        .ctrl_next (ctrl_next),
        .on_ticks  (on_ticks),
        .off_ticks (off_ticks)
    );

    ulb_blinker #(
        .COUNT_BITS(COUNT_BITS)
    ) u_blinker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .is_tick   (in_tick_reg),
        .ctrl      (ctrl),
        .on_ticks  (on_ticks),
        .off_ticks (off_ticks),
        .lit_next  (lit_next),
        .pulse     (pulse)
    );

    // Result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (can_out) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= {5'b0, pulse, ctrl_next.mode_stop, lit_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A held input item stays put while the result stage is blocked
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !can_out) |=> (in_valid_reg && $stable(in_byte_reg)
                                        && $stable(in_tick_reg)))
        else $error("input stage lost an item under stall");

endmodule

/* tb/tb_top.sv */
// Testbench for uart_command_led_blinker: directed table, random command streams, self-check.
`timescale 1ns / 1ps

module tb_top;
    import ulb_pkg::*;

    localparam int CW             = COUNT_BITS_DEF;
    localparam int RAND_ITEMS     = 340;   // per random phase, three phases
    localparam int DRAIN_CYCLES   = 4;     // input and result registers plus margin
    localparam int HOLD_CYCLES    = 80;    // receiver back-pressure stretch
    localparam int WATCHDOG_LIMIT = 2000;  // idle cycles

    // Filler characters: never 'o', 'a', 'f', 'n' or '=' in either case
    localparam logic [7:0] FILL_LO_FIRST = 8'h70;  // 'p'
    localparam logic [7:0] FILL_LO_LAST  = 8'h7A;  // 'z'
    localparam logic [7:0] FILL_UP_FIRST = 8'h50;  // 'P'
    localparam logic [7:0] FILL_UP_LAST  = 8'h5A;  // 'Z'
    localparam logic [7:0] CHR_B_LO      = 8'h62;
    localparam logic [7:0] CHR_P_LO      = 8'h70;
    localparam logic [7:0] CHR_Q_LO      = 8'h71;

    // One result, laid out as m_tdata[2:0]
    typedef struct packed {
        logic echo_pulse;
        logic stop_mode;
        logic led_lit;
    } blink_res_t;

    localparam blink_res_t RES_IDLE      = 3'b000;  // dark, start mode, no echo
    localparam blink_res_t RES_STOP_DARK = 3'b010;  // dark, stop mode, no echo

    typedef struct packed {
        logic       op;
        logic [7:0] rx;
        logic       has_res;
        blink_res_t res;
    } dir_row_t;

    // Directed sequence, run with both periods at 1
    localparam dir_row_t DIR_ROWS [0:26] = '{
        {OP_TICK, CHR_NUL,  1'b1, RES_IDLE},       // on count zero after reset: stays dark
        {OP_BYTE, CHR_O_LO, 1'b1, RES_IDLE},       // 'o' at position 0 is not kept
        {OP_BYTE, CHR_NUL,  1'b1, RES_IDLE},       // short command: position 2 reads zero
        {OP_BYTE, CHR_EQ,   1'b0, RES_IDLE},       // '=' with no digit after it
        {OP_BYTE, CHR_B_LO, 1'b0, RES_IDLE},
        {OP_BYTE, CHR_O_UP, 1'b0, RES_IDLE},
        {OP_BYTE, CHR_NUL,  1'b1, RES_STOP_DARK},  // stop mode entered
        {OP_TICK, 8'hFF,    1'b0, RES_IDLE},       // tick with all-ones data, LED toggles
        {OP_BYTE, CHR_P_LO, 1'b0, RES_IDLE},       // long command, off count wraps
        {OP_BYTE, 8'hFF,    1'b0, RES_IDLE},
        {OP_BYTE, CHR_Q_LO, 1'b0, RES_IDLE},
        {OP_BYTE, CHR_P_LO, 1'b0, RES_IDLE},
        {OP_BYTE, CHR_F_UP, 1'b0, RES_IDLE},
        {OP_BYTE, CHR_EQ,   1'b0, RES_IDLE},
        {OP_BYTE, CHR_NINE, 1'b0, RES_IDLE},
        {OP_BYTE, CHR_NINE, 1'b0, RES_IDLE},
        {OP_BYTE, CHR_NINE, 1'b0, RES_IDLE},
        {OP_BYTE, CHR_NINE, 1'b0, RES_IDLE},
        {OP_BYTE, CHR_NINE, 1'b0, RES_IDLE},
        {OP_BYTE, CHR_NUL,  1'b0, RES_IDLE},
        {OP_TICK, CHR_NUL,  1'b0, RES_IDLE},
        {OP_BYTE, CHR_P_LO, 1'b0, RES_IDLE},       // start command
        {OP_BYTE, CHR_Q_LO, 1'b0, RES_IDLE},
        {OP_BYTE, CHR_A_LO, 1'b0, RES_IDLE},
        {OP_BYTE, CHR_NUL,  1'b0, RES_IDLE},
        {OP_TICK, CHR_NUL,  1'b0, RES_IDLE},       // echo pulses every tick
        {OP_TICK, CHR_NUL,  1'b0, RES_IDLE}
    };

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;   // [7:0] rx_byte
    logic                 s_tuser   = 1'b0;    // [0] opcode
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;             // [0] led_lit, [1] stop_mode, [2] echo_pulse
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Predictor copy of configuration and state
    logic [CFG_W-1:0] pred_stop_half;
    logic [CFG_W-1:0] pred_echo_per;
    logic [2:0]       cmd_pos;
    logic [7:0]       mode_chr;
    logic [7:0]       sel_chr;
    logic             eq_seen;
    logic             num_done;
    logic [CW-1:0]    num_val;
    logic [CW-1:0]    on_cnt;
    logic [CW-1:0]    off_cnt;
    logic [CW-1:0]    run_cnt;
    logic [CW-1:0]    stop_cnt;
    logic [CW-1:0]    echo_cnt;
    logic             in_stop;
    logic             led_on;
    logic             echo_en;

    blink_res_t blink_expect_q[$];
    blink_res_t want_res;
    bit         failed       = 1'b0;
    int         src_idle_pct = 0;
    int         snk_idle_pct = 0;
    bit         hold_req     = 1'b0;
    int         hold_left    = 0;
    int         idle_cycles  = 0;

    uart_command_led_blinker u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Drop the partial command
    function automatic void cmd_clear();
        cmd_pos  = '0;
        mode_chr = '0;
        sel_chr  = '0;
        eq_seen  = 1'b0;
        num_done = 1'b0;
        num_val  = '0;
    endfunction

    // Next LED, mode and echo outputs for one byte or tick
    function automatic blink_res_t blink_predict(input logic op, input logic [7:0] b);
        blink_res_t res;
        res.echo_pulse = 1'b0;
        if (op == OP_TICK) begin
            if (in_stop) begin
                stop_cnt = stop_cnt + 1'b1;
                if (stop_cnt == pred_stop_half) begin
                    led_on   = !led_on;
                    stop_cnt = '0;
                end
                run_cnt = '0;
            end else begin
                run_cnt = run_cnt + 1'b1;
                if (!led_on && run_cnt == on_cnt) begin
                    led_on  = 1'b1;
                    run_cnt = '0;
                end else if (led_on && run_cnt == off_cnt) begin
                    led_on  = 1'b0;
                    run_cnt = '0;
                end
            end
            if (echo_en) begin
                echo_cnt = echo_cnt + 1'b1;
                if (echo_cnt == pred_echo_per) begin
                    res.echo_pulse = 1'b1;
                    echo_cnt       = '0;
                end
            end else begin
                echo_cnt = '0;
            end
        end else if (b == CHR_NUL) begin
            // End of command: decode what was kept
            if (mode_chr == CHR_O_LO || mode_chr == CHR_O_UP) begin
                in_stop = 1'b1;
                echo_en = 1'b0;
            end else if (mode_chr == CHR_A_LO || mode_chr == CHR_A_UP) begin
                in_stop = 1'b0;
                echo_en = 1'b1;
            end else if (eq_seen) begin
                if (sel_chr == CHR_F_LO || sel_chr == CHR_F_UP)
                    off_cnt = num_val;
                else if (sel_chr == CHR_N_LO || sel_chr == CHR_N_UP)
                    on_cnt = num_val;
            end
            cmd_clear();
        end else begin
            if (cmd_pos == POS_MODE)
                mode_chr = b;
            else if (cmd_pos == POS_SEL)
                sel_chr = b;
            if (cmd_pos < POS_SAT)
                cmd_pos = cmd_pos + 1'b1;
            // Number: digits directly after the first '=', wrapping
            if (!eq_seen) begin
                if (b == CHR_EQ) begin
                    eq_seen = 1'b1;
                    num_val = '0;
                end
            end else if (!num_done) begin
                if (b >= CHR_ZERO && b <= CHR_NINE)
                    num_val = CW'(num_val * 10 + (b - CHR_ZERO));
                else
                    num_done = 1'b1;
            end
        end
        res.led_lit   = led_on;
        res.stop_mode = in_stop;
        return res;
    endfunction

    function automatic logic [7:0] fill_char();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(FILL_LO_FIRST, FILL_LO_LAST));
        return 8'($urandom_range(FILL_UP_FIRST, FILL_UP_LAST));
    endfunction

    function automatic logic [7:0] pick_case(input logic [7:0] lo, input logic [7:0] up);
        return ($urandom_range(0, 1) == 0) ? lo : up;
    endfunction

    // Offer one item, wait for the transaction, record its expected result
    task automatic send_item(input logic op, input logic [7:0] b,
                             input logic has_res = 1'b0, input blink_res_t typed_res = '0);
        bit         taken;
        blink_res_t res;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        res = blink_predict(op, b);
        blink_expect_q.push_back(has_res ? typed_res : res);
    endtask

    // Both registers, back to back, while idle
    task automatic cfg_set(input logic [CFG_W-1:0] stop_half, input logic [CFG_W-1:0] echo_per);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_STOP_HALF;
        cfg_wdata <= stop_half;
        @(posedge aclk);
        cfg_addr  <= REG_ECHO_PER;
        cfg_wdata <= echo_per;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        pred_stop_half = stop_half;
        pred_echo_per  = echo_per;
    endtask

    task automatic wait_drained();
        while (blink_expect_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One random sequence: mostly well-formed commands and tick bursts
    task automatic send_rand_seq(inout int sent);
        int         kind;
        int         num_kind;
        logic [7:0] seq[$];
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
            seq.push_back(fill_char());
            seq.push_back(fill_char());
            if (kind < 15)
                seq.push_back(pick_case(CHR_O_LO, CHR_O_UP));
            else if (kind < 30)
                seq.push_back(pick_case(CHR_A_LO, CHR_A_UP));
            else
                seq.push_back(fill_char());
            seq.push_back(fill_char());
            if ($urandom_range(0, 1) == 0)
                seq.push_back(pick_case(CHR_F_LO, CHR_F_UP));
            else
                seq.push_back(pick_case(CHR_N_LO, CHR_N_UP));
            num_kind = $urandom_range(0, 19);
            if (num_kind >= 2)
                seq.push_back(CHR_EQ);
            if (num_kind == 3 || num_kind == 4) begin
                // large number, can wrap
                repeat (5) seq.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
            end else if (num_kind == 5) begin
                seq.push_back(CHR_ZERO);
            end else if (num_kind > 5) begin
                seq.push_back(CHR_ZERO + 8'($urandom_range(1, 6)));
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) seq.push_back(fill_char());
            seq.push_back(CHR_NUL);
        end else if (kind < 70) begin
            repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom_range(0, 255)));
        end
        if (kind < 70) begin
            foreach (seq[i]) send_item(OP_BYTE, seq[i]);
            sent += seq.size();
        end else begin
            repeat ($urandom_range(1, 12)) begin
                send_item(OP_TICK, 8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    task automatic run_rand_phase(input logic [CFG_W-1:0] stop_half,
                                  input logic [CFG_W-1:0] echo_per,
                                  input int src_pct, input int snk_pct, input bit hold);
        int sent;
        sent = 0;
        wait_drained();
        cfg_set(stop_half, echo_per);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        if (hold)
            hold_req = 1'b1;
        while (sent < RAND_ITEMS)
            send_rand_seq(sent);
        s_tvalid <= 1'b0;
    endtask

    // Receiver: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (blink_expect_q.size() == 0) begin
                failed = 1'b1;
                $error("result with none expected: m_tdata %h", m_tdata);
            end else begin
                want_res = blink_expect_q.pop_front();
                if (m_tdata[0] !== want_res.led_lit) begin
                    failed = 1'b1;
                    $error("led_lit: expected %0b, got %0b",
                           want_res.led_lit, m_tdata[0]);
                end
                if (m_tdata[1] !== want_res.stop_mode) begin
                    failed = 1'b1;
                    $error("stop_mode: expected %0b, got %0b",
                           want_res.stop_mode, m_tdata[1]);
                end
                if (m_tdata[2] !== want_res.echo_pulse) begin
                    failed = 1'b1;
                    $error("echo_pulse: expected %0b, got %0b",
                           want_res.echo_pulse, m_tdata[2]);
                end
            end
        end
    end

    // Watchdog: cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("uart_command_led_blinker: mismatch");
            $finish;
        end
    end

    // Main sequence
    initial begin
        pred_stop_half = STOP_HALF_RESET;
        pred_echo_per  = ECHO_PER_RESET;
        cmd_clear();
        on_cnt   = '0;
        off_cnt  = '0;
        run_cnt  = '0;
        stop_cnt = '0;
        echo_cnt = '0;
        in_stop  = 1'b0;
        led_on   = 1'b0;
        echo_en  = 1'b0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table, shortest periods
        src_idle_pct = 18;
        snk_idle_pct = 85;
        cfg_set(16'd1, 16'd1);
        foreach (DIR_ROWS[i])
            send_item(DIR_ROWS[i].op, DIR_ROWS[i].rx, DIR_ROWS[i].has_res, DIR_ROWS[i].res);
        s_tvalid <= 1'b0;

        // Random phases: slow receiver, slow sender, then full rate with a hold-off
        run_rand_phase(CFG_W'($urandom_range(2, 9)), 16'hFFFF, 18, 85, 1'b0);
        run_rand_phase(16'hFFFF, CFG_W'($urandom_range(2, 9)), 85, 18, 1'b0);
        run_rand_phase(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 12)),
                       0, 0, 1'b1);

        wait_drained();
        if (!failed && blink_expect_q.size() == 0) begin
            $display("uart_command_led_blinker: match");
        end else begin
            $display("uart_command_led_blinker: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/ulb_pkg.sv
rtl/ulb_cmd_parser.sv
rtl/ulb_blinker.sv
rtl/uart_command_led_blinker.sv
tb/tb_top.sv
